// File: hdl/ttv_pkg.sv
// Shared types and constants for the triangle tangent vector block.
// Used by ttv_ctrl, ttv_dpath and triangle_tangent_vector; depends on nothing.
package ttv_pkg;

    // Default coordinate datapath width (supported range 16 to 48)
    localparam int COORD_BITS_DEFAULT = 32;

    // Multiplier works on one 16-bit slice of the second operand per cycle
    localparam int CHUNK_W    = 16;
    // Slice counter width: up to four slices, enough for 49-bit edge values
    localparam int CHUNK_BITS = 2;

    // Divider: overflow bit plus 33 quotient bits, one bit per cycle
    localparam int QUOT_BITS   = 34;
    localparam int STEP_BITS   = 6;
    localparam logic [STEP_BITS-1:0] DIV_LAST_STEP = STEP_BITS'(QUOT_BITS - 1);
    // Numerator scale: Q16.16 fraction plus one bit for round-half
    localparam int ROUND_SHIFT = 17;

    // Clamp limits on the rounded magnitude
    localparam logic [32:0] LIMIT_POS = 33'h0_7FFF_FFFF;
    localparam logic [32:0] LIMIT_NEG = 33'h0_8000_0000;

    // Vertex slot within a triangle
    localparam logic [1:0] SLOT_V0 = 2'd0;
    localparam logic [1:0] SLOT_V1 = 2'd1;
    localparam logic [1:0] SLOT_V2 = 2'd2;

    // Sum-of-products term being evaluated
    localparam logic [1:0] TERM_DEN = 2'd0;
    localparam logic [1:0] TERM_X   = 2'd1;
    localparam logic [1:0] TERM_Y   = 2'd2;
    localparam logic [1:0] TERM_Z   = 2'd3;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } vertex_word_t;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic               degenerate;
        logic               saturated;
    } tangent_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                  capture;    // hold vertex 0 or 1
        logic [1:0]            slot;
        logic                  edge_load;  // third vertex: form edge differences
        logic                  mul_step;   // one slice product
        logic                  mul_clear;  // first slice of a term
        logic [1:0]            term;
        logic                  half;       // second product, subtracted
        logic [CHUNK_BITS-1:0] chunk;
        logic                  abs_store;  // split accumulator into sign/magnitude
        logic                  degen_set;
        logic                  div_start;
        logic                  div_step;
        logic                  comp_store; // round, clamp and keep one component
        logic                  out_load;
    } ttv_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic den_zero;
    } ttv_stat_t;

endpackage

// File: hdl/triangle_tangent_vector.sv
// Vertices 0 and 1 are held in registers; the third vertex starts a run to a
// result, set by the 34-step divider run once per component and the 16-bit slice
// multiplier over NUM_CHUNKS = ceil((COORD_BITS+1)/16) slices of the second operand.
// A zero determinant ends the run after the determinant term, with no division.
// No new vertex is taken until the result word is loaded into the output register.
// Synchronous active-low reset clears the vertex count, sequencer and output valid.
module triangle_tangent_vector #(
    parameter int COORD_BITS = ttv_pkg::COORD_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ttv_pkg::vertex_word_t  s_word,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ttv_pkg::tangent_word_t m_word
);

    ttv_pkg::ttv_cmd_t  cmd;
    ttv_pkg::ttv_stat_t stat;

    ttv_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ttv_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .stat    (stat),
        .m_word  (m_word)
    );

    // A degenerate word carries a zero vector and no clamp flag
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.degenerate |->
            m_word.tangent_x == '0 && m_word.tangent_y == '0 &&
            m_word.tangent_z == '0 && !m_word.saturated)
        else $error("degenerate word with nonzero payload");

    // A new result word only comes from an output load
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("output valid without load");

    // Output load never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output word overwritten");

    // Input is closed while the multiplier or divider is busy
    a_busy_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mul_step || cmd.div_step) |-> !s_ready)
        else $error("input open during computation");

endmodule

// File: hdl/ttv_ctrl.sv
// Sequencer for the triangle tangent vector block: vertex count, term,
// slice and divider step counters, output valid. Depends on ttv_pkg.
module ttv_ctrl #(
    parameter int COORD_BITS = ttv_pkg::COORD_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  ttv_pkg::ttv_stat_t  stat,
    output ttv_pkg::ttv_cmd_t   cmd
);

    localparam int CB         = ttv_pkg::CHUNK_BITS;
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int NUM_CHUNKS = (EDGE_BITS + ttv_pkg::CHUNK_W - 1) / ttv_pkg::CHUNK_W;
    localparam logic [CB-1:0] LAST_CHUNK = CB'(NUM_CHUNKS - 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MUL    = 9'b000000010,
        ST_DRAIN  = 9'b000000100,
        ST_ABS    = 9'b000001000,
        ST_DENCHK = 9'b000010000,
        ST_DIVS   = 9'b000100000,
        ST_DIV    = 9'b001000000,
        ST_COMP   = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t                           state_reg, state_next;
    logic [1:0]                       count_reg, count_next;
    logic [1:0]                       term_reg, term_next;
    logic                             half_reg, half_next;
    logic [CB-1:0]                    chunk_reg, chunk_next;
    logic [ttv_pkg::STEP_BITS-1:0]    step_reg, step_next;
    logic                             m_valid_reg, m_valid_next;

    // Next state and command decode
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        term_next    = term_reg;
        half_next    = half_reg;
        chunk_next   = chunk_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.slot     = count_reg;
        cmd.term     = term_reg;
        cmd.half     = half_reg;
        cmd.chunk    = chunk_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (count_reg == ttv_pkg::SLOT_V2) begin
                        cmd.edge_load = 1'b1;
                        count_next    = ttv_pkg::SLOT_V0;
                        term_next     = ttv_pkg::TERM_DEN;
                        half_next     = 1'b0;
                        chunk_next    = '0;
                        state_next    = ST_MUL;
                    end else begin
                        cmd.capture = 1'b1;
                        count_next  = count_reg + 2'd1;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_step  = 1'b1;
                cmd.mul_clear = !half_reg && (chunk_reg == '0);
                if (chunk_reg == LAST_CHUNK) begin
                    chunk_next = '0;
                    if (half_reg) begin
                        half_next  = 1'b0;
                        state_next = ST_DRAIN;
                    end else begin
                        half_next = 1'b1;
                    end
                end else begin
                    chunk_next = chunk_reg + CB'(1);
                end
            end
            ST_DRAIN: begin
                // last slice product lands in the accumulator
                state_next = ST_ABS;
            end
            ST_ABS: begin
                cmd.abs_store = 1'b1;
                state_next = (term_reg == ttv_pkg::TERM_DEN) ? ST_DENCHK : ST_DIVS;
            end
            ST_DENCHK: begin
                if (stat.den_zero) begin
                    cmd.degen_set = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    term_next  = ttv_pkg::TERM_X;
                    state_next = ST_MUL;
                end
            end
            ST_DIVS: begin
                cmd.div_start = 1'b1;
                step_next     = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == ttv_pkg::DIV_LAST_STEP) begin
                    state_next = ST_COMP;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_COMP: begin
                cmd.comp_store = 1'b1;
                if (term_reg == ttv_pkg::TERM_Z) begin
                    state_next = ST_DONE;
                end else begin
                    term_next  = term_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= ttv_pkg::SLOT_V0;
            term_reg    <= ttv_pkg::TERM_DEN;
            half_reg    <= 1'b0;
            chunk_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            term_reg    <= term_next;
            half_reg    <= half_next;
            chunk_reg   <= chunk_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hdl/ttv_dpath.sv
// Datapath for the triangle tangent vector block: vertex hold registers,
// edge differences, slice multiplier-accumulator, restoring divider, output
// register. Depends on ttv_pkg.
module ttv_dpath #(
    parameter int COORD_BITS = ttv_pkg::COORD_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ttv_pkg::vertex_word_t  s_word,
    input  ttv_pkg::ttv_cmd_t      cmd,
    output ttv_pkg::ttv_stat_t     stat,
    output ttv_pkg::tangent_word_t m_word
);

    localparam int CW         = ttv_pkg::CHUNK_W;
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int LOW_BITS   = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int NUM_CHUNKS = (EDGE_BITS + CW - 1) / CW;
    localparam int SLICE_BITS = NUM_CHUNKS * CW;
    localparam int PP_BITS    = EDGE_BITS + CW;
    localparam int ACC_BITS   = 2 * EDGE_BITS + 1;
    localparam int MAG_BITS   = 2 * EDGE_BITS;
    localparam int QB         = ttv_pkg::QUOT_BITS;
    localparam int REM_BITS   = MAG_BITS + QB;

    // Edge register slots
    localparam int ED_DU1    = 0;
    localparam int ED_DV1    = 1;
    localparam int ED_DU2    = 2;
    localparam int ED_DV2    = 3;
    localparam int ED_E1     = 4;
    localparam int ED_E2     = 7;
    localparam int NUM_EDGES = 10;

    // 32-bit field to the coordinate width, sign-extended to edge width
    function automatic logic signed [EDGE_BITS-1:0] widen(input logic [31:0] raw);
        widen = {{(EDGE_BITS - LOW_BITS){raw[LOW_BITS-1]}}, raw[LOW_BITS-1:0]};
    endfunction

    logic [31:0]                 v0_pos_reg [3];
    logic [31:0]                 v1_pos_reg [3];
    logic [31:0]                 v0_tex_reg [2];
    logic [31:0]                 v1_tex_reg [2];
    logic [31:0]                 in_pos [3];

    logic [31:0]                 edge_hi [NUM_EDGES];
    logic [31:0]                 edge_lo [NUM_EDGES];
    logic signed [EDGE_BITS-1:0] edge_diff [NUM_EDGES];
    logic [EDGE_BITS-1:0]        edge_abs [NUM_EDGES];
    logic [EDGE_BITS-1:0]        edge_mag_reg [NUM_EDGES];
    logic                        edge_sgn_reg [NUM_EDGES];

    logic [EDGE_BITS-1:0]        a_sel, b_sel;
    logic                        a_sgn, b_sgn;
    logic [SLICE_BITS-1:0]       b_pad;
    logic [CW-1:0]               b_slice;
    logic [PP_BITS-1:0]          pp_full;
    logic [PP_BITS-1:0]          pp_reg;
    logic [ttv_pkg::CHUNK_BITS-1:0] pp_shift_reg;
    logic                        pp_neg_reg;
    logic                        pp_valid_reg;
    logic [ACC_BITS-1:0]         pp_ext;
    logic [ACC_BITS-1:0]         acc_base, acc_next, acc_reg, acc_abs;

    logic [MAG_BITS-1:0]         den_mag_reg, num_mag_reg;
    logic                        den_sgn_reg, num_sgn_reg;

    logic [REM_BITS-1:0]         rem_reg, dsh_reg;
    logic [QB-1:0]               quot_reg;
    logic                        rem_ge;

    logic                        comp_neg, comp_over;
    logic [32:0]                 comp_limit, comp_mag, comp_val;
    logic [31:0]                 tx_reg, ty_reg, tz_reg;
    logic                        sat_reg, degen_reg;
    ttv_pkg::tangent_word_t      out_reg;

    assign in_pos[0] = s_word.pos_x;
    assign in_pos[1] = s_word.pos_y;
    assign in_pos[2] = s_word.pos_z;

    // Vertex 0 and 1 hold registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            if (cmd.slot == ttv_pkg::SLOT_V0) begin
                v0_pos_reg[0] <= s_word.pos_x;
                v0_pos_reg[1] <= s_word.pos_y;
                v0_pos_reg[2] <= s_word.pos_z;
                v0_tex_reg[0] <= s_word.tex_u;
                v0_tex_reg[1] <= s_word.tex_v;
            end else begin
                v1_pos_reg[0] <= s_word.pos_x;
                v1_pos_reg[1] <= s_word.pos_y;
                v1_pos_reg[2] <= s_word.pos_z;
                v1_tex_reg[0] <= s_word.tex_u;
                v1_tex_reg[1] <= s_word.tex_v;
            end
        end
    end

    // Edge differences from vertex 0, as sign and magnitude
    always_comb begin
        edge_hi[ED_DU1] = v1_tex_reg[0];
        edge_lo[ED_DU1] = v0_tex_reg[0];
        edge_hi[ED_DV1] = v1_tex_reg[1];
        edge_lo[ED_DV1] = v0_tex_reg[1];
        edge_hi[ED_DU2] = s_word.tex_u;
        edge_lo[ED_DU2] = v0_tex_reg[0];
        edge_hi[ED_DV2] = s_word.tex_v;
        edge_lo[ED_DV2] = v0_tex_reg[1];
        for (int k = 0; k < 3; k++) begin
            edge_hi[ED_E1 + k] = v1_pos_reg[k];
            edge_lo[ED_E1 + k] = v0_pos_reg[k];
            edge_hi[ED_E2 + k] = in_pos[k];
            edge_lo[ED_E2 + k] = v0_pos_reg[k];
        end
        for (int i = 0; i < NUM_EDGES; i++) begin
            edge_diff[i] = widen(edge_hi[i]) - widen(edge_lo[i]);
            edge_abs[i]  = edge_diff[i][EDGE_BITS-1] ? EDGE_BITS'(-edge_diff[i])
                                                     : EDGE_BITS'(edge_diff[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.edge_load) begin
            for (int i = 0; i < NUM_EDGES; i++) begin
                edge_mag_reg[i] <= edge_abs[i];
                edge_sgn_reg[i] <= edge_diff[i][EDGE_BITS-1];
            end
        end
    end

    // Operand select: term = a1*dv2 - a2*dv1, a1/a2 from edge 1/2 (du1/du2 for the determinant)
    always_comb begin
        case (cmd.term)
            ttv_pkg::TERM_DEN: begin
                a_sel = cmd.half ? edge_mag_reg[ED_DU2] : edge_mag_reg[ED_DU1];
                a_sgn = cmd.half ? edge_sgn_reg[ED_DU2] : edge_sgn_reg[ED_DU1];
            end
            ttv_pkg::TERM_X: begin
                a_sel = cmd.half ? edge_mag_reg[ED_E2] : edge_mag_reg[ED_E1];
                a_sgn = cmd.half ? edge_sgn_reg[ED_E2] : edge_sgn_reg[ED_E1];
            end
            ttv_pkg::TERM_Y: begin
                a_sel = cmd.half ? edge_mag_reg[ED_E2 + 1] : edge_mag_reg[ED_E1 + 1];
                a_sgn = cmd.half ? edge_sgn_reg[ED_E2 + 1] : edge_sgn_reg[ED_E1 + 1];
            end
            ttv_pkg::TERM_Z: begin
                a_sel = cmd.half ? edge_mag_reg[ED_E2 + 2] : edge_mag_reg[ED_E1 + 2];
                a_sgn = cmd.half ? edge_sgn_reg[ED_E2 + 2] : edge_sgn_reg[ED_E1 + 2];
            end
            default: begin
                a_sel = '0;
                a_sgn = 1'b0;
            end
        endcase
        b_sel   = cmd.half ? edge_mag_reg[ED_DV1] : edge_mag_reg[ED_DV2];
        b_sgn   = cmd.half ? edge_sgn_reg[ED_DV1] : edge_sgn_reg[ED_DV2];
        b_pad   = SLICE_BITS'(b_sel);
        b_slice = b_pad[cmd.chunk * CW +: CW];
        pp_full = {{CW{1'b0}}, a_sel} * {{EDGE_BITS{1'b0}}, b_slice};
    end

    // Slice product register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_valid_reg <= 1'b0;
        end else begin
            pp_valid_reg <= cmd.mul_step;
        end
        if (cmd.mul_step) begin
            pp_reg       <= pp_full;
            pp_shift_reg <= cmd.chunk;
            pp_neg_reg   <= a_sgn ^ b_sgn ^ cmd.half;
        end
    end

    // Accumulate the weighted slice product
    always_comb begin
        pp_ext   = ACC_BITS'(pp_reg) << (pp_shift_reg * CW);
        acc_base = cmd.mul_clear ? '0 : acc_reg;
        if (pp_valid_reg) begin
            acc_next = pp_neg_reg ? acc_base - pp_ext : acc_base + pp_ext;
        end else begin
            acc_next = acc_base;
        end
        acc_abs = acc_reg[ACC_BITS-1] ? -acc_reg : acc_reg;
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Sign and magnitude of the finished term
    always_ff @(posedge aclk) begin
        if (cmd.abs_store) begin
            if (cmd.term == ttv_pkg::TERM_DEN) begin
                den_mag_reg <= acc_abs[MAG_BITS-1:0];
                den_sgn_reg <= acc_reg[ACC_BITS-1];
            end else begin
                num_mag_reg <= acc_abs[MAG_BITS-1:0];
                num_sgn_reg <= acc_reg[ACC_BITS-1];
            end
        end
    end

    assign stat.den_zero = (den_mag_reg == '0);

    // Restoring divider: (|num|*2^17 + |den|) / (2|den|), top bit is overflow
    assign rem_ge = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg  <= REM_BITS'({num_mag_reg, {ttv_pkg::ROUND_SHIFT{1'b0}}})
                      + REM_BITS'(den_mag_reg);
            dsh_reg  <= {den_mag_reg, {QB{1'b0}}};
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QB-2:0], rem_ge};
        end
    end

    // Clamp and sign the rounded quotient
    always_comb begin
        comp_neg   = num_sgn_reg ^ den_sgn_reg;
        comp_limit = comp_neg ? ttv_pkg::LIMIT_NEG : ttv_pkg::LIMIT_POS;
        comp_over  = quot_reg[QB-1] || (quot_reg[32:0] > comp_limit);
        comp_mag   = comp_over ? comp_limit : quot_reg[32:0];
        comp_val   = comp_neg ? -comp_mag : comp_mag;
    end

    always_ff @(posedge aclk) begin
        if (cmd.edge_load) begin
            sat_reg   <= 1'b0;
            degen_reg <= 1'b0;
        end else begin
            if (cmd.degen_set) begin
                degen_reg <= 1'b1;
            end
            if (cmd.comp_store) begin
                sat_reg <= sat_reg | comp_over;
            end
        end
        if (cmd.comp_store) begin
            case (cmd.term)
                ttv_pkg::TERM_X: tx_reg <= comp_val[31:0];
                ttv_pkg::TERM_Y: ty_reg <= comp_val[31:0];
                ttv_pkg::TERM_Z: tz_reg <= comp_val[31:0];
                default: ;
            endcase
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.tangent_x  <= degen_reg ? '0 : tx_reg;
            out_reg.tangent_y  <= degen_reg ? '0 : ty_reg;
            out_reg.tangent_z  <= degen_reg ? '0 : tz_reg;
            out_reg.degenerate <= degen_reg;
            out_reg.saturated  <= !degen_reg && sat_reg;
        end
    end

    assign m_word = out_reg;

endmodule
